// ----- rtl/core/qpcc_pkg.sv -----
// ----------------------------------------------------------------------------
// qpcc_pkg
// Shared types, constants and the micro-op program of the collapse cost unit.
// ----------------------------------------------------------------------------
package qpcc_pkg;

	localparam int VERTICES = 1024;
	localparam int VIDX_W   = $clog2(VERTICES);
	localparam int QWORDS   = 10;
	localparam int VWORDS   = 3;
	localparam int QDEPTH   = VERTICES * QWORDS;
	localparam int VDEPTH   = VERTICES * VWORDS;
	localparam int QADDR_W  = $clog2(QDEPTH);
	localparam int VADDR_W  = $clog2(VDEPTH);

	localparam int IN_W    = 88;
	localparam int OUT_W   = 168;
	localparam int WIDE_W  = 256;
	localparam int XOP_W   = 130;
	localparam int MAG_W   = 192;

	localparam logic [63:0] ONE_Q16 = 64'd65536;

	localparam logic [5:0] SOLVE_LAST = 6'd23;
	localparam logic [5:0] COST_FIRST = 6'd24;
	localparam logic [5:0] COST_LAST  = 6'd43;

	typedef enum logic [1:0] {
		KIND_WQ    = 2'd0,
		KIND_WV    = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ISSUE,
		ST_WAIT,
		ST_CHECK,
		ST_DIV_ISSUE,
		ST_DIV_WAIT,
		ST_CMP,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {XS_W, XS_C, XS_T} xsrc_t;
	typedef enum logic {YS_W, YS_P} ysrc_t;
	typedef enum logic [2:0] {DS_C, DS_D, DS_N, DS_T, DS_COST} dst_t;

	typedef struct packed {
		xsrc_t      xs;
		logic [3:0] xi;
		ysrc_t      ys;
		logic [3:0] yi;
		logic       neg;
		logic       last;
		dst_t       ds;
		logic [2:0] di;
	} uop_t;

	typedef struct packed {
		logic             start;
		logic [XOP_W-1:0] x;
		logic [63:0]      y;
	} mul_req_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [WIDE_W-1:0] num;
		logic [WIDE_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] q;
	} div_rsp_t;

	// quadric word of entry (i,j), row-major
	localparam logic [3:0] QMAP [16] = '{
		4'd0, 4'd1, 4'd2, 4'd3,
		4'd1, 4'd4, 4'd5, 4'd6,
		4'd2, 4'd5, 4'd7, 4'd8,
		4'd3, 4'd6, 4'd8, 4'd9
	};

	function automatic uop_t su(input xsrc_t xs, input logic [3:0] xi, input logic [3:0] yi,
			input logic neg, input logic last, input dst_t ds, input logic [2:0] di);
		uop_t u;
		u.xs   = xs;
		u.xi   = xi;
		u.ys   = YS_W;
		u.yi   = yi;
		u.neg  = neg;
		u.last = last;
		u.ds   = ds;
		u.di   = di;
		return u;
	endfunction

	// Cofactors, determinant and Cramer numerators, then the cost form.
	function automatic uop_t uop_at(input logic [5:0] pc);
		uop_t       u;
		logic [5:0] k;
		u = su(XS_W, 4'd0, 4'd0, 1'b0, 1'b0, DS_C, 3'd0);
		k = pc - COST_FIRST;
		if (pc >= COST_FIRST) begin
			u.ys = YS_P;
			u.yi = {2'b00, k[1:0]};
			u.last = (k[1:0] == 2'd3);
			if (k < 6'd16) begin
				u.xs = XS_W;
				u.xi = QMAP[k[3:0]];
				u.ds = DS_T;
				u.di = {1'b0, k[3:2]};
			end else begin
				u.xs = XS_T;
				u.xi = {2'b00, k[1:0]};
				u.ds = DS_COST;
			end
		end else begin
			case (pc)
				6'd0:    u = su(XS_W, 4'd4, 4'd7, 1'b0, 1'b0, DS_C, 3'd0);
				6'd1:    u = su(XS_W, 4'd5, 4'd5, 1'b1, 1'b1, DS_C, 3'd0);
				6'd2:    u = su(XS_W, 4'd2, 4'd5, 1'b0, 1'b0, DS_C, 3'd1);
				6'd3:    u = su(XS_W, 4'd1, 4'd7, 1'b1, 1'b1, DS_C, 3'd1);
				6'd4:    u = su(XS_W, 4'd1, 4'd5, 1'b0, 1'b0, DS_C, 3'd2);
				6'd5:    u = su(XS_W, 4'd4, 4'd2, 1'b1, 1'b1, DS_C, 3'd2);
				6'd6:    u = su(XS_W, 4'd0, 4'd7, 1'b0, 1'b0, DS_C, 3'd3);
				6'd7:    u = su(XS_W, 4'd2, 4'd2, 1'b1, 1'b1, DS_C, 3'd3);
				6'd8:    u = su(XS_W, 4'd1, 4'd2, 1'b0, 1'b0, DS_C, 3'd4);
				6'd9:    u = su(XS_W, 4'd0, 4'd5, 1'b1, 1'b1, DS_C, 3'd4);
				6'd10:   u = su(XS_W, 4'd0, 4'd4, 1'b0, 1'b0, DS_C, 3'd5);
				6'd11:   u = su(XS_W, 4'd1, 4'd1, 1'b1, 1'b1, DS_C, 3'd5);
				6'd12:   u = su(XS_C, 4'd0, 4'd0, 1'b0, 1'b0, DS_D, 3'd0);
				6'd13:   u = su(XS_C, 4'd1, 4'd1, 1'b0, 1'b0, DS_D, 3'd0);
				6'd14:   u = su(XS_C, 4'd2, 4'd2, 1'b0, 1'b1, DS_D, 3'd0);
				6'd15:   u = su(XS_C, 4'd0, 4'd3, 1'b1, 1'b0, DS_N, 3'd0);
				6'd16:   u = su(XS_C, 4'd1, 4'd6, 1'b1, 1'b0, DS_N, 3'd0);
				6'd17:   u = su(XS_C, 4'd2, 4'd8, 1'b1, 1'b1, DS_N, 3'd0);
				6'd18:   u = su(XS_C, 4'd1, 4'd3, 1'b1, 1'b0, DS_N, 3'd1);
				6'd19:   u = su(XS_C, 4'd3, 4'd6, 1'b1, 1'b0, DS_N, 3'd1);
				6'd20:   u = su(XS_C, 4'd4, 4'd8, 1'b1, 1'b1, DS_N, 3'd1);
				6'd21:   u = su(XS_C, 4'd2, 4'd3, 1'b1, 1'b0, DS_N, 3'd2);
				6'd22:   u = su(XS_C, 4'd4, 4'd6, 1'b1, 1'b0, DS_N, 3'd2);
				6'd23:   u = su(XS_C, 4'd5, 4'd8, 1'b1, 1'b1, DS_N, 3'd2);
				default: u = su(XS_W, 4'd0, 4'd0, 1'b0, 1'b0, DS_C, 3'd0);
			endcase
		end
		return u;
	endfunction

endpackage

// ----- rtl/core/qpcc_ram.sv -----
// ----------------------------------------------------------------------------
// qpcc_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module qpcc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

// ----- rtl/core/qpcc_mul.sv -----
// ----------------------------------------------------------------------------
// qpcc_mul
// Sign-magnitude multiplier, 128 x 64 bits, one 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
module qpcc_mul import qpcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [XOP_W-1:0] x_abs;
	logic [63:0]      y_abs;
	logic [127:0]     xm_q;
	logic [63:0]      ym_q;
	logic             neg_q;
	logic [2:0]       k_q;
	logic             busy_q;
	logic [63:0]      pp_s1;
	logic [2:0]       sh_s1;
	logic             v_s1;
	logic             last_s1;
	logic [MAG_W-1:0] acc_q;
	logic             done_q;

	assign x_abs = req.x[XOP_W-1] ? (~req.x + 1'b1) : req.x;
	assign y_abs = req.y[63] ? (~req.y + 1'b1) : req.y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= v_s1 && last_s1;
			v_s1   <= busy_q;
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				last_s1 <= (k_q == 3'd7);
				k_q     <= k_q + 3'd1;
				if (k_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			xm_q  <= x_abs[127:0];
			ym_q  <= y_abs;
			neg_q <= req.x[XOP_W-1] ^ req.y[63];
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + (MAG_W'(pp_s1) << {sh_s1, 5'b00000});
		end
		if (busy_q) begin
			pp_s1 <= 64'(xm_q[{k_q[1:0], 5'b00000} +: 32]) * 64'(ym_q[{k_q[2], 5'b00000} +: 32]);
			sh_s1 <= {1'b0, k_q[1:0]} + {2'b00, k_q[2]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign rsp.mag  = acc_q;

endmodule

// ----- rtl/core/qpcc_div.sv -----
// ----------------------------------------------------------------------------
// qpcc_div
// Restoring divider, one quotient bit a cycle; quotient of (num * 2^16) / den
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module qpcc_div import qpcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [WIDE_W-1:0] num_abs;
	logic [WIDE_W-1:0] den_abs;
	logic [WIDE_W-1:0] ua_q;
	logic [WIDE_W-1:0] ub_q;
	logic [WIDE_W-1:0] r_q;
	logic [WIDE_W-1:0] qt_q;
	logic [WIDE_W:0]   r2;
	logic              ge;
	logic [7:0]        cnt_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic              neg_q;
	logic [31:0]       res_q;
	logic              sat_n;
	logic              sat_p;

	assign num_abs = req.num[WIDE_W-1] ? (~req.num + 1'b1) : req.num;
	assign den_abs = req.den[WIDE_W-1] ? (~req.den + 1'b1) : req.den;
	assign r2      = {r_q, ua_q[WIDE_W-1]};
	assign ge      = (r2 >= {1'b0, ub_q});
	assign sat_n   = (|qt_q[WIDE_W-1:32]) || (qt_q[31] && (|qt_q[30:0]));
	assign sat_p   = |qt_q[WIDE_W-1:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'd255;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= num_abs << 16;
			ub_q  <= den_abs;
			neg_q <= req.num[WIDE_W-1] ^ req.den[WIDE_W-1];
			r_q   <= '0;
			qt_q  <= '0;
		end else if (busy_q) begin
			r_q  <= ge ? WIDE_W'(r2 - {1'b0, ub_q}) : r2[WIDE_W-1:0];
			qt_q <= {qt_q[WIDE_W-2:0], ge};
			ua_q <= ua_q << 1;
		end
		if (fin_q) begin
			if (neg_q) begin
				res_q <= sat_n ? 32'h8000_0000 : (~qt_q[31:0] + 32'd1);
			end else begin
				res_q <= sat_p ? 32'h7FFF_FFFF : qt_q[31:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = res_q;

endmodule

// ----- rtl/core/quadric_pair_collapse_cost_unit.sv -----
// ----------------------------------------------------------------------------
// quadric_pair_collapse_cost_unit
// Vertex quadric and position stores with an edge-collapse cost evaluator.
// Writes and no-ops: once accepted, acknowledged via ST_RESP and the output register.
// Pair query: store reads, then 104 products on one 32x32 multiplier and,
//   unless the determinant is zero, three quotients on one bit-serial divider.
// One request at a time; a finished result waits in the output register.
// Reset (arst_n low, asynchronous) clears control; store contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module quadric_pair_collapse_cost_unit import qpcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// vertex_a[9:0], vertex_b[19:10], word_index[23:20], value[87:24]
	input  logic [IN_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// cost[63:0], best_x[95:64], best_y[127:96], best_z[159:128],
	// chosen_point[161:160], solvable[162], zero[167:163]
	output logic [OUT_W-1:0] m_tdata,
	// is_query[0]
	output logic [0:0]       m_tuser
);

	state_t state_q, state_d;

	logic              accept;
	logic              out_free;
	logic [VIDX_W-1:0] in_va;
	logic [3:0]        in_wi;
	logic [63:0]       in_val;
	logic [31:0]       in_val32;

	logic               q_en, q_we;
	logic [QADDR_W-1:0] q_addr, q_waddr;
	logic [63:0]        q_rdata;
	logic               v_en, v_we;
	logic [VADDR_W-1:0] v_addr, v_waddr;
	logic [31:0]        v_rdata;

	logic [QADDR_W-1:0] qa_base_q, qb_base_q;
	logic [VADDR_W-1:0] va_base_q, vb_base_q;
	logic [4:0]         ld_cnt_q;
	logic [4:0]         ld_prev;
	logic [3:0]         wk;
	logic [1:0]         vk;

	logic [63:0]       wq_q   [QWORDS];
	logic [31:0]       pa_q   [VWORDS];
	logic [31:0]       pb_q   [VWORDS];
	logic [31:0]       mid    [VWORDS];
	logic [31:0]       cand0_q[VWORDS];
	logic [31:0]       pt_cur [VWORDS];
	logic [31:0]       pt_best[VWORDS];
	logic [XOP_W-1:0]  cof_q  [6];
	logic [XOP_W-1:0]  t_q    [4];
	logic [WIDE_W-1:0] n_q    [3];
	logic [WIDE_W-1:0] d_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] cost_acc_q;
	logic [WIDE_W-1:0] addend;
	logic [WIDE_W-1:0] sum;

	logic [5:0] pc_q;
	logic [1:0] cidx_q;
	logic [1:0] dc_q;
	logic       solv_q;
	logic       query_q;
	uop_t       u;

	logic [63:0] cost_sat;
	logic        cost_fits;
	logic [63:0] best_cost_q;
	logic [1:0]  best_idx_q;

	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;
	logic             m_user_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	div_req_t dreq;
	div_rsp_t drsp;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return s;
	endfunction

	assign in_va    = VIDX_W'(s_tdata[9:0]);
	assign in_wi    = s_tdata[23:20];
	assign in_val   = s_tdata[87:24];
	assign in_val32 = ((&in_val[63:31]) || !(|in_val[63:31])) ? in_val[31:0]
		: (in_val[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign q_waddr = QADDR_W'(in_va) * QADDR_W'(QWORDS) + QADDR_W'(in_wi);
	assign v_waddr = VADDR_W'(in_va) * VADDR_W'(VWORDS) + VADDR_W'(in_wi);
	assign ld_prev = ld_cnt_q - 5'd1;
	assign wk      = (ld_prev < 5'd10) ? ld_prev[3:0] : 4'(ld_prev - 5'd10);
	assign vk      = (ld_prev < 5'd3) ? ld_prev[1:0] : 2'(ld_prev - 5'd3);

	assign u = uop_at(pc_q);

	// candidate points
	always_comb begin
		for (int c = 0; c < VWORDS; c++) begin
			mid[c] = 32'(({pa_q[c][31], pa_q[c]} + {pb_q[c][31], pb_q[c]}) >> 1);
			case (cidx_q)
				2'd0:    pt_cur[c] = solv_q ? cand0_q[c] : mid[c];
				2'd1:    pt_cur[c] = mid[c];
				2'd2:    pt_cur[c] = pa_q[c];
				default: pt_cur[c] = pb_q[c];
			endcase
			case (best_idx_q)
				2'd0:    pt_best[c] = solv_q ? cand0_q[c] : mid[c];
				2'd1:    pt_best[c] = mid[c];
				2'd2:    pt_best[c] = pa_q[c];
				default: pt_best[c] = pb_q[c];
			endcase
		end
	end

	// operand select
	always_comb begin
		mreq.start = (state_q == ST_ISSUE);
		case (u.xs)
			XS_W:    mreq.x = {{(XOP_W-64){wq_q[u.xi][63]}}, wq_q[u.xi]};
			XS_C:    mreq.x = cof_q[u.xi[2:0]];
			XS_T:    mreq.x = t_q[u.xi[1:0]];
			default: mreq.x = '0;
		endcase
		case (u.ys)
			YS_W:    mreq.y = wq_q[u.yi];
			YS_P:    mreq.y = (u.yi[1:0] == 2'd3) ? ONE_Q16
				: {{32{pt_cur[u.yi[1:0]][31]}}, pt_cur[u.yi[1:0]]};
			default: mreq.y = '0;
		endcase
	end

	assign addend    = {{(WIDE_W-MAG_W){1'b0}}, mrsp.mag};
	assign sum       = (mrsp.neg ^ u.neg) ? (acc_q - addend) : (acc_q + addend);
	assign cost_fits = (&cost_acc_q[WIDE_W-1:95]) || !(|cost_acc_q[WIDE_W-1:95]);
	assign cost_sat  = cost_fits ? cost_acc_q[95:32]
		: (cost_acc_q[WIDE_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == KIND_QUERY) ? ST_LOAD : ST_RESP;
				end
			end
			ST_LOAD: begin
				if (ld_cnt_q == 5'd20) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (mrsp.done) begin
					if (pc_q == SOLVE_LAST) begin
						state_d = ST_CHECK;
					end else if (pc_q == COST_LAST) begin
						state_d = ST_CMP;
					end else begin
						state_d = ST_ISSUE;
					end
				end
			end
			ST_CHECK:     state_d = (d_q != '0) ? ST_DIV_ISSUE : ST_ISSUE;
			ST_DIV_ISSUE: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (drsp.done) begin
					state_d = (dc_q == 2'd2) ? ST_ISSUE : ST_DIV_ISSUE;
				end
			end
			ST_CMP: state_d = (cidx_q == 2'd3) ? ST_RESP : ST_ISSUE;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		dreq.start = 1'b0;
		dreq.num   = n_q[dc_q];
		dreq.den   = d_q;
		q_we       = 1'b0;
		v_we       = 1'b0;
		q_en       = 1'b0;
		v_en       = 1'b0;
		q_addr     = q_waddr;
		v_addr     = v_waddr;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				q_we = accept && (s_tuser == KIND_WQ) && (in_wi < 4'd10);
				v_we = accept && (s_tuser == KIND_WV) && (in_wi < 4'd3);
				q_en = q_we;
				v_en = v_we;
			end
			ST_LOAD: begin
				q_en   = (ld_cnt_q < 5'd20);
				v_en   = (ld_cnt_q < 5'd6);
				q_addr = (ld_cnt_q < 5'd10) ? (qa_base_q + QADDR_W'(ld_cnt_q))
					: (qb_base_q + QADDR_W'(ld_cnt_q - 5'd10));
				v_addr = (ld_cnt_q < 5'd3) ? (va_base_q + VADDR_W'(ld_cnt_q))
					: (vb_base_q + VADDR_W'(ld_cnt_q - 5'd3));
			end
			ST_DIV_ISSUE: dreq.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			cidx_q    <= '0;
			dc_q      <= '0;
			ld_cnt_q  <= '0;
			solv_q    <= 1'b0;
			query_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						query_q  <= (s_tuser == KIND_QUERY);
						ld_cnt_q <= '0;
						pc_q     <= '0;
						solv_q   <= 1'b0;
					end
				end
				ST_LOAD: ld_cnt_q <= ld_cnt_q + 5'd1;
				ST_WAIT: begin
					if (mrsp.done && pc_q != SOLVE_LAST && pc_q != COST_LAST) begin
						pc_q <= pc_q + 6'd1;
					end
				end
				ST_CHECK: begin
					solv_q <= (d_q != '0);
					dc_q   <= '0;
					pc_q   <= COST_FIRST;
					cidx_q <= '0;
				end
				ST_DIV_WAIT: begin
					if (drsp.done) begin
						dc_q <= dc_q + 2'd1;
					end
				end
				ST_CMP: begin
					cidx_q <= cidx_q + 2'd1;
					pc_q   <= COST_FIRST;
				end
				default: ;
			endcase
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == ST_RESP && out_free) begin
				m_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					qa_base_q <= QADDR_W'(in_va) * QADDR_W'(QWORDS);
					qb_base_q <= QADDR_W'(VIDX_W'(s_tdata[19:10])) * QADDR_W'(QWORDS);
					va_base_q <= VADDR_W'(in_va) * VADDR_W'(VWORDS);
					vb_base_q <= VADDR_W'(VIDX_W'(s_tdata[19:10])) * VADDR_W'(VWORDS);
					acc_q     <= '0;
				end
			end
			ST_LOAD: begin
				if (ld_cnt_q != 5'd0) begin
					if (ld_prev < 5'd10) begin
						wq_q[wk] <= q_rdata;
					end else begin
						wq_q[wk] <= sat_add(wq_q[wk], q_rdata);
					end
					if (ld_prev < 5'd3) begin
						pa_q[vk] <= v_rdata;
					end else if (ld_prev < 5'd6) begin
						pb_q[vk] <= v_rdata;
					end
				end
			end
			ST_WAIT: begin
				if (mrsp.done) begin
					acc_q <= u.last ? '0 : sum;
					if (u.last) begin
						case (u.ds)
							DS_C:    cof_q[u.di] <= sum[XOP_W-1:0];
							DS_D:    d_q <= sum;
							DS_N:    n_q[u.di[1:0]] <= sum;
							DS_T:    t_q[u.di[1:0]] <= sum[XOP_W-1:0];
							DS_COST: cost_acc_q <= sum;
							default: ;
						endcase
					end
				end
			end
			ST_DIV_WAIT: begin
				if (drsp.done) begin
					cand0_q[dc_q] <= drsp.q;
				end
			end
			ST_CMP: begin
				if (cidx_q == 2'd0 || $signed(cost_sat) <= $signed(best_cost_q)) begin
					best_cost_q <= cost_sat;
					best_idx_q  <= cidx_q;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					m_user_q <= query_q;
					if (query_q) begin
						m_data_q <= {5'b00000, solv_q, best_idx_q, pt_best[2], pt_best[1],
							pt_best[0], best_cost_q};
					end else begin
						m_data_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

	qpcc_ram #(.WIDTH(64), .DEPTH(QDEPTH)) u_qstore (
		.clk   (clk),
		.en    (q_en),
		.we    (q_we),
		.addr  (q_addr),
		.wdata (in_val),
		.rdata (q_rdata)
	);

	qpcc_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_vstore (
		.clk   (clk),
		.en    (v_en),
		.we    (v_we),
		.addr  (v_addr),
		.wdata (in_val32),
		.rdata (v_rdata)
	);

	qpcc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	qpcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	a_resp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && out_free) |=> m_tvalid)
		else $error("result not presented");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (pc_q <= COST_LAST))
		else $error("micro-op counter out of program");

	a_cmp_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (pc_q == COST_LAST))
		else $error("cost compare before cost program done");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("acknowledge carries data");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadric pair collapse cost unit testbench
// Loads vertex quadrics and positions, runs pair evaluations and checks every
// acknowledgement and cost result against an in-bench 256-bit fixed-point
// predictor, with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench import qpcc_pkg::*; ;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int POOL_SIZE   = 24;
	localparam logic [12:0] ALL_WORDS = 13'h1fff;

	typedef logic [9:0][255:0] qsum_t;
	typedef logic [8:0][255:0] mat3_t;

	typedef struct {
		logic        is_query;
		logic [63:0] cost;
		logic [31:0] x, y, z;
		logic [1:0]  pt;
		logic        solv;
	} cost_result_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	logic [63:0]  quadric_mem [QDEPTH];
	logic [31:0]  position_mem [VDEPTH];
	logic [12:0]  loaded_words [VERTICES];
	int           loaded_vertices [$];
	int           vertex_pool [POOL_SIZE];
	cost_result_t pending_results [$];
	int           fail_count, query_count, singular_count, write_count, cycles;
	bit           steady;

	quadric_pair_collapse_cost_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic signed [255:0] det3(input mat3_t m);
		logic signed [255:0] e [9];
		logic signed [255:0] acc;
		for (int k = 0; k < 9; k++) e[k] = $signed(m[k]);
		acc = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[2] * e[3] * e[7]
			- e[2] * e[4] * e[6] - e[1] * e[3] * e[8] - e[0] * e[5] * e[7];
		return acc;
	endfunction

	function automatic logic signed [63:0] form_cost(input qsum_t q,
			input logic signed [31:0] x, y, z);
		logic signed [255:0] p [4];
		logic signed [255:0] acc, w;
		int a, b;
		p[0] = x;
		p[1] = y;
		p[2] = z;
		p[3] = 256'sd65536;
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				a = (i < j) ? i : j;
				b = (i < j) ? j : i;
				w = $signed(q[a * 4 - a * (a + 1) / 2 + b]);
				acc = acc + p[i] * p[j] * w;
			end
		end
		acc = acc >>> 32;
		if (acc > 256'sh7fffffffffffffff) return 64'sh7fffffffffffffff;
		if (acc < -256'sh8000000000000000) return 64'sh8000000000000000;
		return acc[63:0];
	endfunction

	function automatic cost_result_t evaluate_pair(input int va, input int vb);
		qsum_t q;
		mat3_t m, mm;
		logic signed [255:0] d, num, quo, ext;
		logic signed [64:0] s;
		logic signed [32:0] t;
		logic signed [31:0] cand [4][3];
		logic signed [63:0] cst [4];
		int best;
		cost_result_t r;
		for (int i = 0; i < 10; i++) begin
			s = $signed(quadric_mem[va * 10 + i]) + $signed(quadric_mem[vb * 10 + i]);
			if (s[64] != s[63]) s = s[64] ? -65'sh8000000000000000 : 65'sh7fffffffffffffff;
			ext = s;
			q[i] = ext;
		end
		m[0] = q[0]; m[1] = q[1]; m[2] = q[2];
		m[3] = q[1]; m[4] = q[4]; m[5] = q[5];
		m[6] = q[2]; m[7] = q[5]; m[8] = q[7];
		d = det3(m);
		for (int i = 0; i < 3; i++) begin
			cand[2][i] = $signed(position_mem[va * 3 + i]);
			cand[3][i] = $signed(position_mem[vb * 3 + i]);
			t = cand[2][i] + cand[3][i];
			cand[1][i] = t >>> 1;
		end
		for (int c = 0; c < 3; c++) begin
			if (d != 0) begin
				mm = m;
				mm[c] = -q[3];
				mm[3 + c] = -q[6];
				mm[6 + c] = -q[8];
				num = det3(mm) * 256'sd65536;
				quo = num / d;
				if (quo > 256'sd2147483647) cand[0][c] = 32'sh7fffffff;
				else if (quo < -256'sd2147483648) cand[0][c] = 32'sh80000000;
				else cand[0][c] = quo[31:0];
			end else begin
				cand[0][c] = cand[1][c];
			end
		end
		best = 0;
		for (int i = 0; i < 4; i++) begin
			cst[i] = form_cost(q, cand[i][0], cand[i][1], cand[i][2]);
			if (i > 0 && cst[i] <= cst[best]) best = i;
		end
		r.is_query = 1'b1;
		r.cost = cst[best];
		r.x = cand[best][0];
		r.y = cand[best][1];
		r.z = cand[best][2];
		r.pt = best[1:0];
		r.solv = (d != 0);
		return r;
	endfunction

	function automatic cost_result_t apply_request(input kind_t k, input int va, input int vb,
			input int wi, input logic [63:0] val);
		cost_result_t r;
		logic signed [63:0] sv;
		r = '{default: '0};
		sv = val;
		case (k)
			KIND_WQ: begin
				if (wi < QWORDS) begin
					quadric_mem[va * 10 + wi] = val;
					loaded_words[va][wi] = 1'b1;
				end
			end
			KIND_WV: begin
				if (wi < VWORDS) begin
					if (sv > 64'sd2147483647) position_mem[va * 3 + wi] = 32'h7fffffff;
					else if (sv < -64'sd2147483648) position_mem[va * 3 + wi] = 32'h80000000;
					else position_mem[va * 3 + wi] = val[31:0];
					loaded_words[va][10 + wi] = 1'b1;
				end
			end
			KIND_QUERY: begin
				r = evaluate_pair(va, vb);
				query_count++;
				if (!r.solv) singular_count++;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(input kind_t k, input int va, input int vb, input int wi,
			input logic [63:0] val);
		int gap;
		bit was_ready;
		cost_result_t r;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {val, wi[3:0], vb[9:0], va[9:0]};
		do begin
			@(posedge clk);
			was_ready = s_tready;
		end while (!was_ready);
		was_ready = (loaded_words[va] == ALL_WORDS);
		r = apply_request(k, va, vb, wi, val);
		pending_results = {pending_results, r};
		if (k != KIND_QUERY && k != KIND_NOP) write_count++;
		if (!was_ready && loaded_words[va] == ALL_WORDS) loaded_vertices = {loaded_vertices, va};
		@(negedge clk);
	endtask

	function automatic logic [63:0] random_quadric_word();
		logic signed [63:0] w;
		w = {$urandom, $urandom};
		return w >>> $urandom_range(0, 44);
	endfunction

	function automatic logic [63:0] random_coordinate();
		logic signed [63:0] w;
		if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
		w = $signed($urandom);
		return w >>> $urandom_range(0, 16);
	endfunction

	task automatic check_field(input string name, input logic [63:0] expected,
			input logic [63:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %h actual %h", name, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cost_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				check_field("is_query", e.is_query, m_tuser[0]);
				check_field("cost", e.cost, m_tdata[63:0]);
				check_field("best_x", e.x, m_tdata[95:64]);
				check_field("best_y", e.y, m_tdata[127:96]);
				check_field("best_z", e.z, m_tdata[159:128]);
				check_field("chosen_point", e.pt, m_tdata[161:160]);
				check_field("solvable", e.solv, m_tdata[162]);
			end
		end
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic load_vertex(input int v, input logic [63:0] qw [10],
			input logic [63:0] cw [3]);
		for (int i = 0; i < QWORDS; i++) send_request(KIND_WQ, v, $urandom_range(0, 1023), i, qw[i]);
		for (int i = 0; i < VWORDS; i++) send_request(KIND_WV, v, $urandom_range(0, 1023), i, cw[i]);
	endtask

	// extreme words, saturated sums and coordinates, all-zero quadric ties
	task automatic test_field_extremes();
		logic [63:0] qw [10];
		logic [63:0] cw [3];
		for (int i = 0; i < 10; i++) qw[i] = i[0] ? 64'h8000000000000000 : 64'h7fffffffffffffff;
		cw = '{64'h0000001234567890, 64'hfffff00000000000, 64'h000000007fffffff};
		load_vertex(0, qw, cw);
		qw = '{default: '0};
		cw = '{64'hffffffff80000000, 64'h0000000000010000, 64'hffffffffffffffff};
		load_vertex(VERTICES - 1, qw, cw);
		send_request(KIND_QUERY, VERTICES - 1, VERTICES - 1, 0, '0);
		send_request(KIND_QUERY, 0, VERTICES - 1, 15, '1);
		send_request(KIND_QUERY, 0, 0, 0, '0);
	endtask

	// ignored writes and the unused kind
	task automatic test_ignored_requests();
		send_request(KIND_NOP, 1023, 1023, 15, '1);
		send_request(KIND_WQ, 0, 5, 10, '1);
		send_request(KIND_WQ, 1023, 0, 15, '0);
		send_request(KIND_WV, 0, 0, 3, '1);
		send_request(KIND_WV, 1023, 1023, 15, 64'h5555aaaa5555aaaa);
		send_request(KIND_QUERY, 0, VERTICES - 1, 0, '0);
	endtask

	task automatic test_random_traffic(input int items);
		int r, va, vb;
		for (int n = 0; n < items; n++) begin
			steady = (n >= items / 3 && n < items / 3 + 120);
			r = $urandom_range(0, 99);
			if (r < 28) begin
				va = loaded_vertices[$urandom_range(0, loaded_vertices.size() - 1)];
				vb = loaded_vertices[$urandom_range(0, loaded_vertices.size() - 1)];
				send_request(KIND_QUERY, va, vb, $urandom_range(0, 15), {$urandom, $urandom});
			end else if (r < 88) begin
				va = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
				if ($urandom_range(0, 2) != 0)
					send_request(KIND_WQ, va, $urandom_range(0, 1023), $urandom_range(0, 9),
						random_quadric_word());
				else
					send_request(KIND_WV, va, $urandom_range(0, 1023), $urandom_range(0, 2),
						random_coordinate());
			end else begin
				case ($urandom_range(0, 2))
					0: send_request(KIND_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 15), {$urandom, $urandom});
					1: send_request(KIND_WQ, $urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(10, 15), {$urandom, $urandom});
					default: send_request(KIND_WV, $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 15), random_coordinate());
				endcase
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		steady = 1'b0;
		fail_count = 0;
		query_count = 0;
		singular_count = 0;
		write_count = 0;
		cycles = 0;
		for (int v = 0; v < VERTICES; v++) loaded_words[v] = '0;
		for (int i = 0; i < POOL_SIZE; i++) vertex_pool[i] = $urandom_range(1, 1022);
		vertex_pool[0] = 0;
		vertex_pool[1] = 1023;
		vertex_pool[2] = 341;
		vertex_pool[3] = 682;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_field_extremes();
		test_ignored_requests();
		test_random_traffic(915);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d pair evaluations (%0d singular) and %0d store writes.",
			query_count, singular_count, write_count);
		$display("%0d of %0d vertices were fully loaded.", loaded_vertices.size(), VERTICES);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/qpcc_pkg.sv
rtl/core/qpcc_ram.sv
rtl/core/qpcc_mul.sv
rtl/core/qpcc_div.sv
rtl/core/quadric_pair_collapse_cost_unit.sv
tb/sv/testbench.sv
